// File: src/avtd_pkg.sv
// Package for the adaptive voice threshold decider.
// Holds sequencer state, mode and register index codes, and reset defaults.
// No dependencies.
package avtd_pkg;

   typedef enum logic [1:0] {
      MODE_ABSOLUTE = 2'd0,
      MODE_PERCENT  = 2'd1,
      MODE_ADAPT    = 2'd2,
      MODE_DYN      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_DECISION_MODE  = 3'd0,
      REG_THRESHOLD      = 3'd1,
      REG_INIT_FRAMES    = 3'd2,
      REG_ADAPT_SMOOTH   = 3'd3,
      REG_ADAPT_GAIN     = 3'd4,
      REG_DYN_MIN_SPAN   = 3'd5,
      REG_DYN_COEFFS     = 3'd6,
      REG_UNUSED         = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_FRAC, ST_THR, ST_DIV, ST_WIDEN,
      ST_SMA, ST_SMB, ST_SMW, ST_SQ, ST_ZERO, ST_SQRT, ST_GAIN, ST_ATHR,
      ST_MSQ0, ST_MSQ1, ST_MSQ2, ST_MSQ3, ST_MSQW, ST_M2, ST_VAR, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      TGT_HIGH, TGT_LOW, TGT_MEAN
   } target_type;

   localparam int CRIT_W  = 32;
   localparam int FC_W    = 17;
   localparam int WIDE_W  = 52;
   localparam int ACC_W   = 98;
   localparam int OPND_W  = 33;

   localparam logic [FC_W-1:0]   FC_MAX          = '1;
   localparam logic [15:0]       ADAPT_SMOOTH_RST = 16'd62259;
   localparam logic [15:0]       ADAPT_GAIN_RST   = 16'd768;
   localparam logic [16:0]       Q_ONE            = 17'd65536;
   // ceil(2^35 / 10): floor(x * RECIP10 >> 35) == x / 10 for any 32-bit x
   localparam logic [OPND_W-1:0] RECIP10          = 33'h0CCCCCCCD;

endpackage

// File: src/avtd_chan_if.sv
// Valid/ready channel interfaces for the decider's request and response.
// Uses avtd_pkg for field widths.
interface avtd_req_if import avtd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CRIT_W-1:0] criterion;
   logic                     restart;
   modport source (output valid, criterion, restart, input ready);
   modport sink   (input valid, criterion, restart, output ready);
endinterface

interface avtd_rsp_if import avtd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     voice;
   logic signed [CRIT_W-1:0] threshold;
   logic                     in_init;
   modport source (output valid, voice, threshold, in_init, input ready);
   modport sink   (input valid, voice, threshold, in_init, output ready);
endinterface

// File: src/adaptive_voice_threshold_decider.sv
// Absolute decides at dispatch; percent adds a span product; dyn copies (init), widens or
// tracks (two smoothings, span product); adaptive seeds on its first frame, else runs a
// 32-step square root, a gain product and, when adapting, a mean smoothing, a four-part
// mean-square product and a variance update. One frame at a time; response stalls hold it.
// Reset (synchronous, active high) restores control, configuration and tracked state.
// Depends on avtd_pkg and the channel interfaces in avtd_chan_if.sv.
module adaptive_voice_threshold_decider
   import avtd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   avtd_req_if.sink     req_ch,
   avtd_rsp_if.source   rsp_ch,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   // configuration registers
   logic [1:0]               mode_ff;
   logic signed [31:0]       tset_ff;
   logic [15:0]              init_ff;
   logic [15:0]              asmooth_ff;
   logic [15:0]              again_ff;
   logic [30:0]              dmin_ff;
   logic [63:0]              dcoef_ff;

   // tracked state
   logic [FC_W-1:0]          fc_ff, fc_in;
   logic signed [31:0]       lo_ff, lo_in, hi_ff, hi_in, mean_ff, mean_in;
   logic [63:0]              msq_ff, msq_in, var_ff, var_in;

   // per-frame working registers
   state_type                state_ff, state_in;
   target_type               tgt_ff, tgt_in;
   logic signed [31:0]       cri_ff, cri_in;
   logic [FC_W-1:0]          idx_ff, idx_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [16:0]              q_ff, q_in;
   logic signed [WIDE_W-1:0] thr_ff, thr_in;
   logic                     voice_ff, voice_in;
   logic signed [32:0]       span_ff, span_in;
   logic [63:0]              c2_ff, c2_in;
   logic [34:0]              rem_ff, rem_in;
   logic [31:0]              root_ff, root_in;
   logic [63:0]              rad_ff, rad_in;
   logic [4:0]               cnt_ff, cnt_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_voice_ff, rsp_voice_in;
   logic signed [31:0]       rsp_thr_ff, rsp_thr_in;
   logic                     rsp_init_ff, rsp_init_in;

   // shared multiplier controls
   logic signed [OPND_W-1:0] mul_a, mul_b;
   logic                     mul_en, mul_clr, mul_sh32;
   logic signed [65:0]       prod;
   logic signed [ACC_W-1:0]  prod_ext;

   logic req_xfer;
   logic load_rsp;

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] mx, mn;
      mx = WIDE_W'(32'sh7FFFFFFF);
      mn = -WIDE_W'(64'sd2147483648);
      if (x > mx) sat32 = 32'sh7FFFFFFF;
      else if (x < mn) sat32 = 32'sh80000000;
      else sat32 = x[31:0];
   endfunction

   assign req_xfer      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.voice     = rsp_voice_ff;
   assign rsp_ch.threshold = rsp_thr_ff;
   assign rsp_ch.in_init   = rsp_init_ff;

   // one signed 33x33 product, shifted by 0 or 32 into the accumulator
   assign prod     = mul_a * mul_b;
   assign prod_ext = mul_sh32 ? (ACC_W'(prod) <<< 32) : ACC_W'(prod);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_ABSOLUTE;
         tset_ff    <= '0;
         init_ff    <= '0;
         asmooth_ff <= ADAPT_SMOOTH_RST;
         again_ff   <= ADAPT_GAIN_RST;
         dmin_ff    <= '0;
         dcoef_ff   <= '0;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_DECISION_MODE: mode_ff    <= csr_wdata[1:0];
            REG_THRESHOLD:     tset_ff    <= csr_wdata[31:0];
            REG_INIT_FRAMES:   init_ff    <= csr_wdata[15:0];
            REG_ADAPT_SMOOTH:  asmooth_ff <= csr_wdata[15:0];
            REG_ADAPT_GAIN:    again_ff   <= csr_wdata[15:0];
            REG_DYN_MIN_SPAN:  dmin_ff    <= csr_wdata[30:0];
            REG_DYN_COEFFS:    dcoef_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      logic [FC_W-1:0] n_dyn;
      n_dyn    = (init_ff > 16'd1) ? FC_W'(init_ff) : FC_W'(1);
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_xfer) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (mode_type'(mode_ff))
               MODE_ABSOLUTE: state_in = ST_FINISH;
               MODE_PERCENT:  state_in = ST_FRAC;
               MODE_ADAPT:    state_in = (idx_ff == '0) ? ST_SQ : ST_SQRT;
               default: begin
                  if (idx_ff < n_dyn)       state_in = ST_FINISH;
                  else if (idx_ff == n_dyn) state_in = ST_DIV;
                  else                      state_in = ST_SMA;
               end
            endcase
         end
         ST_SMA:   state_in = ST_SMB;
         ST_SMB:   state_in = ST_SMW;
         ST_SMW: begin
            case (tgt_ff)
               TGT_HIGH: state_in = ST_SMA;
               TGT_LOW:  state_in = ST_FRAC;
               default:  state_in = ST_SQ;
            endcase
         end
         ST_FRAC:  state_in = ST_THR;
         ST_THR:   state_in = ST_FINISH;
         ST_DIV:   state_in = ST_WIDEN;
         ST_WIDEN: state_in = ST_FINISH;
         ST_SQ:    state_in = (idx_ff == '0) ? ST_ZERO : ST_MSQ0;
         ST_ZERO:  state_in = ST_FINISH;
         ST_SQRT:  if (cnt_ff == '0) state_in = ST_GAIN;
         ST_GAIN:  state_in = ST_ATHR;
         ST_ATHR: begin
            if ((WIDE_W'(cri_ff) < thr_in) || (idx_ff <= FC_W'(init_ff)))
               state_in = ST_SMA;
            else
               state_in = ST_FINISH;
         end
         ST_MSQ0:  state_in = ST_MSQ1;
         ST_MSQ1:  state_in = ST_MSQ2;
         ST_MSQ2:  state_in = ST_MSQ3;
         ST_MSQ3:  state_in = ST_MSQW;
         ST_MSQW:  state_in = ST_M2;
         ST_M2:    state_in = ST_VAR;
         ST_VAR:   state_in = ST_FINISH;
         ST_FINISH: if (load_rsp) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   assign load_rsp = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // datapath and multiplier control per state
   always_comb begin
      logic [FC_W-1:0]   n_dyn;
      logic signed [32:0] hmax, lmin, wext, tsum;
      logic signed [31:0] sm_old;
      logic [34:0]        rem_t, trial;
      logic [63:0]        m2;

      n_dyn  = (init_ff > 16'd1) ? FC_W'(init_ff) : FC_W'(1);
      hmax   = '0;
      lmin   = '0;
      wext   = '0;
      tsum   = '0;
      rem_t  = '0;
      trial  = '0;
      m2     = '0;
      case (tgt_ff)
         TGT_HIGH: sm_old = hi_ff;
         TGT_LOW:  sm_old = lo_ff;
         default:  sm_old = mean_ff;
      endcase

      fc_in    = fc_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mean_in  = mean_ff;
      msq_in   = msq_ff;
      var_in   = var_ff;
      tgt_in   = tgt_ff;
      cri_in   = cri_ff;
      idx_in   = idx_ff;
      q_in     = q_ff;
      thr_in   = thr_ff;
      voice_in = voice_ff;
      span_in  = span_ff;
      c2_in    = c2_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      rad_in   = rad_ff;
      cnt_in   = cnt_ff;
      mul_a    = '0;
      mul_b    = '0;
      mul_en   = 1'b0;
      mul_clr  = 1'b0;
      mul_sh32 = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_voice_in = rsp_voice_ff;
      rsp_thr_in   = rsp_thr_ff;
      rsp_init_in  = rsp_init_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cri_in = req_ch.criterion;
               idx_in = req_ch.restart ? '0 : fc_ff;
               fc_in  = (idx_in == FC_MAX) ? FC_MAX : idx_in + FC_W'(1);
            end
         end
         ST_DISPATCH: begin
            voice_in = 1'b0;
            thr_in   = WIDE_W'(cri_ff);
            case (mode_type'(mode_ff))
               MODE_ABSOLUTE: begin
                  thr_in   = WIDE_W'(tset_ff);
                  voice_in = (cri_ff >= tset_ff);
               end
               MODE_PERCENT: begin
                  if ((idx_ff == '0) || (idx_ff < FC_W'(init_ff))) begin
                     lo_in = cri_ff;
                     hi_in = cri_ff;
                  end else begin
                     if (cri_ff < lo_ff) lo_in = cri_ff;
                     if (cri_ff > hi_ff) hi_in = cri_ff;
                  end
               end
               MODE_ADAPT: begin
                  // start the square root of the variance, two bits a step
                  rad_in  = var_ff;
                  rem_in  = '0;
                  root_in = '0;
                  cnt_in  = '1;
               end
               default: begin
                  if (idx_ff < n_dyn) begin
                     lo_in = cri_ff;
                     hi_in = cri_ff;
                  end else if (idx_ff > n_dyn) begin
                     tgt_in = TGT_HIGH;
                     q_in   = (hi_ff < cri_ff) ? {1'b0, dcoef_ff[15:0]}
                                               : {1'b0, dcoef_ff[31:16]};
                  end
               end
            endcase
         end
         // smoothing: floor((q*old + (1-q)*new) / 2^16)
         ST_SMA: begin
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'(q_ff);
            mul_b   = OPND_W'(sm_old);
         end
         ST_SMB: begin
            mul_en = 1'b1;
            mul_a  = OPND_W'(Q_ONE - q_ff);
            mul_b  = OPND_W'(cri_ff);
         end
         ST_SMW: begin
            case (tgt_ff)
               TGT_HIGH: begin
                  hi_in  = acc_ff[47:16];
                  tgt_in = TGT_LOW;
                  q_in   = (lo_ff > cri_ff) ? {1'b0, dcoef_ff[47:32]}
                                            : {1'b0, dcoef_ff[63:48]};
               end
               TGT_LOW:  lo_in   = acc_ff[47:16];
               default:  mean_in = acc_ff[47:16];
            endcase
         end
         ST_FRAC: begin
            span_in = 33'(hi_ff) - 33'(lo_ff);
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'(tset_ff);
            mul_b   = span_in;
         end
         ST_THR: begin
            thr_in = WIDE_W'(lo_ff) + acc_ff[67:16];
            if (mode_type'(mode_ff) == MODE_PERCENT)
               voice_in = (WIDE_W'(cri_ff) >= thr_in);
            else
               voice_in = (WIDE_W'(cri_ff) > thr_in)
                          && (span_ff > $signed({2'b00, dmin_ff}));
         end
         ST_DIV: begin
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'({2'b00, dmin_ff});
            mul_b   = RECIP10;
         end
         ST_WIDEN: begin
            // widen the tracked span by a tenth of the least span
            wext = $signed({1'b0, acc_ff[66:35]});
            hmax = (hi_ff > cri_ff) ? 33'(hi_ff) : 33'(cri_ff);
            lmin = (lo_ff < cri_ff) ? 33'(lo_ff) : 33'(cri_ff);
            tsum = hmax + wext;
            hi_in = sat32(WIDE_W'(tsum));
            tsum = lmin - wext;
            lo_in = sat32(WIDE_W'(tsum));
         end
         ST_SQ: begin
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'(cri_ff);
            mul_b   = OPND_W'(cri_ff);
         end
         ST_ZERO: begin
            mean_in = cri_ff;
            msq_in  = acc_ff[63:0];
            var_in  = '0;
         end
         ST_SQRT: begin
            rem_t  = {rem_ff[32:0], rad_ff[63:62]};
            trial  = {1'b0, root_ff, 2'b01};
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            cnt_in = cnt_ff - 5'd1;
         end
         ST_GAIN: begin
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'(again_ff);
            mul_b   = OPND_W'({1'b0, root_ff});
         end
         ST_ATHR: begin
            thr_in   = WIDE_W'(mean_ff) + acc_ff[59:8];
            voice_in = 1'b1;
            if ((WIDE_W'(cri_ff) < thr_in) || (idx_ff <= FC_W'(init_ff))) begin
               voice_in = 1'b0;
               tgt_in   = TGT_MEAN;
               q_in     = {1'b0, asmooth_ff};
            end
         end
         // mean square: sum of four 32x17 partial products, then drop 16 bits
         ST_MSQ0: begin
            c2_in   = acc_ff[63:0];
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'({1'b0, msq_ff[31:0]});
            mul_b   = OPND_W'(q_ff);
         end
         ST_MSQ1: begin
            mul_en   = 1'b1;
            mul_sh32 = 1'b1;
            mul_a    = OPND_W'({1'b0, msq_ff[63:32]});
            mul_b    = OPND_W'(q_ff);
         end
         ST_MSQ2: begin
            mul_en = 1'b1;
            mul_a  = OPND_W'({1'b0, c2_ff[31:0]});
            mul_b  = OPND_W'(Q_ONE - q_ff);
         end
         ST_MSQ3: begin
            mul_en   = 1'b1;
            mul_sh32 = 1'b1;
            mul_a    = OPND_W'({1'b0, c2_ff[63:32]});
            mul_b    = OPND_W'(Q_ONE - q_ff);
         end
         ST_MSQW: msq_in = acc_ff[79:16];
         ST_M2: begin
            mul_en  = 1'b1;
            mul_clr = 1'b1;
            mul_a   = OPND_W'(mean_ff);
            mul_b   = OPND_W'(mean_ff);
         end
         ST_VAR: begin
            m2     = acc_ff[63:0];
            var_in = (msq_ff > m2) ? msq_ff - m2 : '0;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_voice_in = voice_ff;
               rsp_thr_in   = sat32(thr_ff);
               rsp_init_in  = (idx_ff <= FC_W'(init_ff));
            end
         end
         default: ;
      endcase

      acc_in = acc_ff;
      if (mul_en) acc_in = (mul_clr ? ACC_W'(0) : acc_ff) + prod_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fc_ff        <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         mean_ff      <= '0;
         msq_ff       <= '0;
         var_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fc_ff        <= fc_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         mean_ff      <= mean_in;
         msq_ff       <= msq_in;
         var_ff       <= var_in;
      end
   end

   // payload and working registers: no reset needed
   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      cri_ff       <= cri_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      q_ff         <= q_in;
      thr_ff       <= thr_in;
      voice_ff     <= voice_in;
      span_ff      <= span_in;
      c2_ff        <= c2_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      rad_ff       <= rad_in;
      cnt_ff       <= cnt_in;
      rsp_voice_ff <= rsp_voice_in;
      rsp_thr_ff   <= rsp_thr_in;
      rsp_init_ff  <= rsp_init_in;
   end

   // a transfer always advances the frame counter off zero
   a_fc_moves: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (fc_ff != '0))
      else $error("frame counter left at zero after a transfer");

   // hold off new requests while a frame is in progress
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ch.ready)
      else $error("request taken while busy");

   // a finished frame whose result slot is free must post its result
   a_post: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("result dropped at finish");

   // the square root runs only in adaptive mode
   a_sqrt_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (mode_ff == MODE_ADAPT))
      else $error("square root outside adaptive mode");

endmodule

// File: tb/sv/tb_adaptive_voice_threshold_decider.sv
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_voice_threshold_decider: runs all four
// decision modes against a built-in frame predictor, with random valid/ready idling.
// Depends on avtd_pkg and the channel interfaces in avtd_chan_if.sv.

import avtd_pkg::*;

typedef struct packed {
   logic              voice;
   logic signed [31:0] threshold;
   logic              in_init;
} decision_type;

class decision_scoreboard;
   // register copies
   mode_type         mode;
   int               thr_setting;
   int unsigned      init_frames;
   int unsigned      smoothing;
   int unsigned      spread_gain;
   int unsigned      min_span;
   longint unsigned  coeffs;
   // tracked state
   int unsigned      frame_count;
   int               low_track, high_track, mean;
   longint unsigned  mean_sq, variance;

   decision_type     pending_q[$];
   int               mismatches;
   int               checked;

   function new();
      mode = MODE_ABSOLUTE; thr_setting = 0; init_frames = 0;
      smoothing = 62259; spread_gain = 768; min_span = 0; coeffs = 0;
      frame_count = 0; low_track = 0; high_track = 0; mean = 0;
      mean_sq = 0; variance = 0; mismatches = 0; checked = 0;
   endfunction

   function int sat32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return int'(x);
   endfunction

   function int blend(int unsigned q, int old_v, int new_v);
      longint s;
      s = longint'(q) * old_v + longint'(65536 - q) * new_v;
      return int'(s >>> 16);
   endfunction

   function longint unsigned blend_wide(int unsigned q, longint unsigned a,
                                        longint unsigned b);
      longint unsigned hi, lo;
      hi = (a >> 16) * q + (b >> 16) * (65536 - q);
      lo = (a & 64'hFFFF) * q + (b & 64'hFFFF) * (65536 - q);
      return hi + (lo >> 16);
   endfunction

   function longint unsigned root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function longint span_point(int lo, longint span);
      return longint'(lo) + ((longint'(thr_setting) * span) >>> 16);
   endfunction

   // predict the decision for one accepted frame and queue it
   function void note_frame(logic signed [31:0] crit, logic restart);
      int unsigned     idx, n;
      int              cri, hi, lo;
      longint          thr, span, w;
      bit              voice;
      longint unsigned c2, sd, m2;
      decision_type    d;
      int unsigned     qa, qb;
      cri = crit;
      idx = restart ? 0 : frame_count;
      thr = 0;
      voice = 0;
      frame_count = (idx >= FC_MAX) ? FC_MAX : idx + 1;
      case (mode)
         MODE_ABSOLUTE: begin
            thr = thr_setting;
            voice = longint'(cri) >= thr;
         end
         MODE_PERCENT: begin
            if (idx == 0 || idx < init_frames) begin
               low_track = cri;
               high_track = cri;
            end else begin
               if (cri < low_track) low_track = cri;
               if (cri > high_track) high_track = cri;
            end
            thr = span_point(low_track, longint'(high_track) - low_track);
            voice = longint'(cri) >= thr;
         end
         MODE_ADAPT: begin
            c2 = longint'(cri) * cri;
            if (idx == 0) begin
               thr = cri;
               mean = cri;
               mean_sq = c2;
               variance = 0;
            end else begin
               sd = root(variance);
               thr = longint'(mean) + longint'((spread_gain * sd) >> 8);
               if (longint'(cri) < thr || idx <= init_frames) begin
                  mean = blend(smoothing, mean, cri);
                  mean_sq = blend_wide(smoothing, mean_sq, c2);
                  m2 = longint'(mean) * mean;
                  variance = (mean_sq > m2) ? mean_sq - m2 : 0;
               end else begin
                  voice = 1;
               end
            end
         end
         default: begin
            n = (init_frames > 1) ? init_frames : 1;
            if (idx < n) begin
               high_track = cri;
               low_track = cri;
               thr = cri;
            end else if (idx == n) begin
               w = min_span / 10;
               hi = (high_track > cri) ? high_track : cri;
               lo = (low_track < cri) ? low_track : cri;
               high_track = sat32(longint'(hi) + w);
               low_track = sat32(longint'(lo) - w);
               thr = cri;
            end else begin
               qa = (high_track < cri) ? coeffs[15:0] : coeffs[31:16];
               qb = (low_track > cri) ? coeffs[47:32] : coeffs[63:48];
               high_track = blend(qa, high_track, cri);
               low_track = blend(qb, low_track, cri);
               span = longint'(high_track) - low_track;
               thr = span_point(low_track, span);
               voice = (longint'(cri) > thr) && (span > longint'(min_span));
            end
         end
      endcase
      d.voice = voice;
      d.threshold = sat32(thr);
      d.in_init = (idx <= init_frames);
      pending_q.push_back(d);
   endfunction

   function void check_decision(decision_type got);
      decision_type want;
      checked++;
      if (pending_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: unexpected decision voice=%0b thr=%0d init=%0b",
                     got.voice, got.threshold, got.in_init);
         return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"ERROR: decision %0d: expected voice=%0b thr=%0d init=%0b,",
                      " got voice=%0b thr=%0d init=%0b"},
                     checked, want.voice, want.threshold, want.in_init,
                     got.voice, got.threshold, got.in_init);
      end
   endfunction
endclass

module tb_adaptive_voice_threshold_decider;

   localparam int CYCLE_LIMIT = 600000;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   avtd_req_if req_ch ();
   avtd_rsp_if rsp_ch ();

   adaptive_voice_threshold_decider u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   decision_scoreboard sb = new();

   int  cycles;
   int  frames_sent;
   int  stall_left;
   bit  quiet;          // no idling on either side in the closing stretch
   int  mode_frames[4];

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // monitor: note accepted frames, then check accepted decisions
   always @(posedge clock) begin
      decision_type got;
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_frame(req_ch.criterion, req_ch.restart);
         mode_frames[sb.mode]++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.voice = rsp_ch.voice;
         got.threshold = rsp_ch.threshold;
         got.in_init = rsp_ch.in_init;
         sb.check_decision(got);
      end
   end

   // response side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // write one register; the caller drops the write enable after a batch
   task automatic write_reg(reg_index_type idx, logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // write every register and mirror it into the predictor
   task automatic configure(mode_type m, int thr, int unsigned init,
                            int unsigned smooth_q, int unsigned gain,
                            int unsigned span, longint unsigned coeffs);
      write_reg(REG_DECISION_MODE, 64'(m));
      write_reg(REG_THRESHOLD, {32'h0, thr});
      write_reg(REG_INIT_FRAMES, 64'(init[15:0]));
      write_reg(REG_ADAPT_SMOOTH, 64'(smooth_q[15:0]));
      write_reg(REG_ADAPT_GAIN, 64'(gain[15:0]));
      write_reg(REG_DYN_MIN_SPAN, 64'(span[30:0]));
      write_reg(REG_DYN_COEFFS, coeffs);
      csr_wr_en <= 1'b0;
      sb.mode = m;
      sb.thr_setting = thr;
      sb.init_frames = init[15:0];
      sb.smoothing = smooth_q[15:0];
      sb.spread_gain = gain[15:0];
      sb.min_span = span[30:0];
      sb.coeffs = coeffs;
      @(negedge clock);
   endtask

   // present one frame; entered and left at a falling edge
   task automatic send_frame(int crit, bit restart);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.criterion <= crit;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      frames_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every decision has come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // criterion with a drifting base, occasional loud frames and extremes
   function automatic int pick_crit(int base);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 60)
         return base + $signed($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
      if (sel < 75) return base + $signed($urandom_range(0, 32'h3FFFFF));
      if (sel < 85) return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      return $urandom;
   endfunction

   function automatic int pick_thr(mode_type m);
      case ($urandom_range(0, 5))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 0;
         default:
            return (m == MODE_ABSOLUTE) ? int'($urandom)
                                        : int'($urandom_range(0, 32'h10000));
      endcase
   endfunction

   function automatic int unsigned pick_q();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 65535;
         2: return 62259;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   initial begin
      int             base;
      int             count;
      mode_type       m;
      longint unsigned cf;
      cycles = 0;
      frames_sent = 0;
      stall_left = 0;
      quiet = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = REG_DECISION_MODE;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.criterion = '0;
      req_ch.restart = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset defaults, absolute mode at zero level
      send_frame(0, 1'b1);
      send_frame(-1, 1'b0);
      send_frame(32'h7FFFFFFF, 1'b0);
      send_frame(32'h80000000, 1'b0);
      drain();
      configure(MODE_ABSOLUTE, 32'h7FFFFFFF, 2, 62259, 768, 0, 0);
      send_frame(32'h7FFFFFFF, 1'b1);
      send_frame(32'h7FFFFFFE, 1'b0);
      drain();
      // percent: full span at full fraction drives the threshold past 32 bits
      configure(MODE_PERCENT, 32'h7FFFFFFF, 0, 62259, 768, 0, 0);
      send_frame(32'h80000000, 1'b1);
      send_frame(32'h7FFFFFFF, 1'b0);
      send_frame(0, 1'b0);
      drain();
      // adaptive: silence then a loud frame
      configure(MODE_ADAPT, 0, 1, 65535, 65535, 0, 0);
      send_frame(32'h00010000, 1'b1);
      send_frame(32'h00020000, 1'b0);
      send_frame(32'h00008000, 1'b0);
      send_frame(32'h7FFFFFFF, 1'b0);
      drain();
      // dyn: widening saturates; then percent mode reseeds the shared tracks during init
      configure(MODE_DYN, 32'h8000, 0, 0, 0, 32'h7FFFFFFF, '1);
      send_frame(32'h80000000, 1'b1);
      send_frame(32'h7FFFFFFF, 1'b0);
      send_frame(0, 1'b0);
      send_frame(32'h00500000, 1'b0);
      drain();
      configure(MODE_PERCENT, 32'h10000, 65535, 0, 0, 0, 0);
      send_frame(32'h00100000, 1'b0);
      send_frame(-32'sh00100000, 1'b0);
      drain();

      // random phases, each mode several times with varied registers
      for (int p = 0; p < 16; p++) begin
         m = mode_type'(p % 4);
         cf = {$urandom, $urandom};
         if (p % 5 == 0) cf = (p % 2) ? '1 : '0;
         configure(m, pick_thr(m),
                   ($urandom_range(0, 19) == 0) ? 65535 : $urandom_range(0, 6),
                   pick_q(), pick_q(),
                   ($urandom_range(0, 3) == 0) ? 32'h7FFFFFFF : $urandom_range(0, 32'hFFFFF),
                   cf);
         if (p == 14) quiet = 1'b1;
         base = $signed($urandom_range(0, 32'h1FFFFF)) - 32'h100000;
         count = 40 + $urandom_range(0, 15);
         for (int i = 0; i < count; i++) begin
            send_frame(pick_crit(base), (i == 0) || ($urandom_range(0, 49) == 0));
            if ($urandom_range(0, 19) == 0)
               base = base + $signed($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
         end
         drain();
      end

      repeat (60) @(negedge clock);
      $display("Covered %0d frames: absolute %0d, percent %0d, adaptive %0d, dynamics %0d;",
               frames_sent, mode_frames[0], mode_frames[1], mode_frames[2], mode_frames[3]);
      $display("%0d decisions checked, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/avtd_pkg.sv
src/avtd_chan_if.sv
src/adaptive_voice_threshold_decider.sv
tb/sv/tb_adaptive_voice_threshold_decider.sv
